/* src/xcpd_pkg.sv */
// xcpd_pkg: types and constants shared by the XOR-chain packet decoder.
// No dependencies; used by every module of the decoder.
`timescale 1ns / 1ps
`default_nettype none

package xcpd_pkg;

  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  // Register index, taken from paddr[2]
  localparam logic REG_STATIC_KEY = 1'b0;

  typedef struct packed {
    logic [7:0] in_byte;
    logic [7:0] random_key;
    logic       first_of_packet;
    logic       last_of_packet;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       checksum_ok;
  } out_item_t;

  // Entry handed from the front end to the back end: first mask already applied.
  typedef struct packed {
    logic [7:0] mid_byte;
    logic [7:0] position;
    logic [7:0] random_key;
    logic       first;
    logic       last;
  } q_entry_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_head_t;

endpackage : xcpd_pkg

`default_nettype wire

/* src/xcpd_front.sv */
// xcpd_front: accepts input transactions, tracks position and previous
// cipher byte, applies the first (static-key) mask. Uses xcpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module xcpd_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept,
  input  wire xcpd_pkg::in_item_t item,
  input  wire logic [7:0]        static_key,
  output xcpd_pkg::q_entry_t     entry
);

  logic [7:0] prev_cipher_r, prev_cipher_nxt;
  logic [7:0] pos_r, pos_nxt;
  logic [7:0] pc_eff;
  logic [7:0] n;

  always_comb begin
    // a packet start restarts the chain
    pc_eff = item.first_of_packet ? 8'd0 : prev_cipher_r;
    n      = item.first_of_packet ? 8'd1 : 8'(pos_r + 8'd1);

    entry.mid_byte   = item.in_byte ^ 8'(pc_eff + static_key + n);
    entry.position   = n;
    entry.random_key = item.random_key;
    entry.first      = item.first_of_packet;
    entry.last       = item.last_of_packet;

    prev_cipher_nxt = accept ? item.in_byte : prev_cipher_r;
    pos_nxt         = accept ? n : pos_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_cipher_r <= 8'd0;
      pos_r         <= 8'd0;
    end else begin
      prev_cipher_r <= prev_cipher_nxt;
      pos_r         <= pos_nxt;
    end
  end

endmodule : xcpd_front

`default_nettype wire

/* src/xcpd_queue.sv */
// xcpd_queue: small FIFO between the front and back ends of the decoder.
// Uses xcpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module xcpd_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire xcpd_pkg::q_entry_t push_entry,
  input  wire logic               pop,
  output logic                    full,
  output xcpd_pkg::q_head_t       head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  xcpd_pkg::q_entry_t mem [DEPTH];

  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  always_comb begin
    full       = (count_r == FULL_CNT);
    head.valid = (count_r != '0);
    head.entry = mem[rd_ptr_r];

    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : PTR_W'(wr_ptr_r + 1'b1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : PTR_W'(rd_ptr_r + 1'b1);
    end
    if (push && !pop) begin
      count_nxt = CNT_W'(count_r + 1'b1);
    end else if (pop && !push) begin
      count_nxt = CNT_W'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule : xcpd_queue

`default_nettype wire

/* src/xcpd_back.sv */
// xcpd_back: applies the second (packet-key) mask, keeps the payload sum and
// checksum, and holds the result in an output register. Uses xcpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module xcpd_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire xcpd_pkg::q_head_t head,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output xcpd_pkg::out_item_t    out_data
);

  logic [7:0] prev_plain_r, prev_plain_nxt;
  logic [7:0] key_r, key_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] held_r, held_nxt;
  logic       out_valid_r, out_valid_nxt;
  xcpd_pkg::out_item_t out_r, out_nxt;

  logic [7:0] pp_eff;
  logic [7:0] dec;

  always_comb begin
    pop = head.valid && (!out_valid_r || !out_stall);

    pp_eff = head.entry.first ? 8'd0 : prev_plain_r;
    key_nxt = head.entry.first ? head.entry.random_key : key_r;
    dec = head.entry.mid_byte ^ 8'(pp_eff + key_nxt + head.entry.position);

    prev_plain_nxt = prev_plain_r;
    sum_nxt        = sum_r;
    held_nxt       = held_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r && out_stall;

    if (pop) begin
      prev_plain_nxt = head.entry.mid_byte;
      if (head.entry.first) begin
        held_nxt = dec;
        sum_nxt  = 8'd0;
      end else begin
        sum_nxt  = 8'(sum_r + dec);
      end
      out_nxt.out_byte    = dec;
      out_nxt.out_last    = head.entry.last;
      out_nxt.checksum_ok = head.entry.last && (sum_nxt == held_nxt);
      out_valid_nxt       = 1'b1;
    end else begin
      key_nxt = key_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_plain_r <= 8'd0;
      key_r        <= 8'd0;
      sum_r        <= 8'd0;
      held_r       <= 8'd0;
      out_valid_r  <= 1'b0;
    end else begin
      prev_plain_r <= prev_plain_nxt;
      key_r        <= key_nxt;
      sum_r        <= sum_nxt;
      held_r       <= held_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule : xcpd_back

`default_nettype wire

/* src/xor_chain_packet_decoder_unit.sv */
// Channel  | Direction | Handshake          | Payload
// in_      | input     | in_valid/in_stall   | xcpd_pkg::in_item_t
// out_     | output    | out_valid/out_stall | xcpd_pkg::out_item_t
// cfg APB  | input     | psel/penable/pready | static_key at address 0
//
// One transaction per cycle in steady state while out_stall stays low; out_valid rises
// after acceptance once the entry has been written to the queue and then to the output register.
// The queue of QUEUE_DEPTH entries lets input proceed while a result is stalled.
// rst_n is synchronous; reset clears the chain state and static_key.
// Depends on xcpd_pkg, xcpd_front, xcpd_queue, xcpd_back.
`timescale 1ns / 1ps
`default_nettype none

module xor_chain_packet_decoder_unit #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire xcpd_pkg::in_item_t                  in_data,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output xcpd_pkg::out_item_t                      out_data,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [xcpd_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire logic [xcpd_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [xcpd_pkg::APB_DATA_W-1:0]          prdata,
  output logic                                     pready
);

  logic [7:0] static_key_r, static_key_nxt;
  logic       cfg_wr;
  logic       in_accept;
  logic       q_full;
  logic       q_pop;
  xcpd_pkg::q_entry_t front_entry;
  xcpd_pkg::q_head_t  q_head;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    static_key_nxt = static_key_r;
    if (cfg_wr && (paddr[2] == xcpd_pkg::REG_STATIC_KEY)) begin
      static_key_nxt = pwdata[7:0];
    end
    prdata = '0;
    if (paddr[2] == xcpd_pkg::REG_STATIC_KEY) begin
      prdata = {{(xcpd_pkg::APB_DATA_W-8){1'b0}}, static_key_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      static_key_r <= 8'd0;
    end else begin
      static_key_r <= static_key_nxt;
    end
  end

  assign in_stall  = q_full;
  assign in_accept = in_valid && !q_full;

  xcpd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_accept),
    .item       (in_data),
    .static_key (static_key_r),
    .entry      (front_entry)
  );

  xcpd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_accept),
    .push_entry (front_entry),
    .pop        (q_pop),
    .full       (q_full),
    .head       (q_head)
  );

  xcpd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule : xor_chain_packet_decoder_unit

`default_nettype wire

/* src/xcpd_checker.sv */
// xcpd_assert: port-level assertions for the XOR-chain packet decoder,
// bound to xor_chain_packet_decoder_unit. Uses xcpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module xcpd_assert (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire xcpd_pkg::out_item_t out_data,
  input wire logic                pready
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  // checksum flag only on the last transaction of a packet
  a_ok_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.out_last || !out_data.checksum_ok))
    else $error("checksum_ok set on a non-last transaction");

  // reset empties the pipeline and the queue; checked as no result offered and the queue not full
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule : xcpd_assert

bind xor_chain_packet_decoder_unit xcpd_assert u_xcpd_assert (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data),
  .pready    (pready)
);

`default_nettype wire
